// File: rtl/ppp_pkg.sv
// Package: widths, codes and shared types of the point-to-plane projection block.
`timescale 1ns / 1ps
package ppp_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int MAG_WIDTH   = COORD_WIDTH + 1;
  localparam int PROD_WIDTH  = 2 * MAG_WIDTH;
  localparam int SUM_WIDTH   = PROD_WIDTH + 2;
  localparam int DEN_WIDTH   = 2 * COORD_WIDTH;
  localparam int LIMIT_WIDTH = 63;
  localparam int QUO_WIDTH   = COORD_WIDTH + 1;
  localparam int REM_WIDTH   = DEN_WIDTH + 1;
  localparam int QSHIFT      = QUO_WIDTH - FRAC_BITS;
  localparam int OVF_WIDTH   = DEN_WIDTH + QSHIFT;
  localparam int SUMV_WIDTH  = 2 * COORD_WIDTH + 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_WIDTH  = $clog2(QUEUE_DEPTH);
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 64;

  localparam logic [LIMIT_WIDTH-1:0] NEAR_RESET     = LIMIT_WIDTH'(1);
  localparam logic [LIMIT_WIDTH-1:0] IN_PLANE_RESET = LIMIT_WIDTH'(429);

  localparam logic [QUO_WIDTH-1:0] T_POS_MAX = {2'b00, {(COORD_WIDTH-1){1'b1}}};
  localparam logic [QUO_WIDTH-1:0] T_NEG_MAX = {2'b01, {(COORD_WIDTH-1){1'b0}}};

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  localparam coord_t CMAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  typedef logic [1:0] status_t;
  localparam status_t ST_PROJECTED = 2'd0;
  localparam status_t ST_PLANE     = 2'd1;
  localparam status_t ST_IN_PLANE  = 2'd2;
  localparam status_t ST_SATURATED = 2'd3;

  localparam logic REG_NEAR     = 1'b0;
  localparam logic REG_IN_PLANE = 1'b1;

  typedef struct packed {
    coord_t px, py, pz;
    coord_t qx, qy, qz;
    coord_t nx, ny, nz;
  } geom_t;

  typedef struct packed {
    geom_t                g;
    status_t              kind;
    logic                 num_neg;
    logic                 ovf;
    logic [SUM_WIDTH-1:0] mag;
    logic [DEN_WIDTH-1:0] den;
  } entry_t;

  typedef struct packed {
    logic [LIMIT_WIDTH-1:0] near;
    logic [LIMIT_WIDTH-1:0] in_plane;
  } limits_t;
endpackage

// File: rtl/ppp_if.sv
// Interfaces: input item channel and result channel.
`timescale 1ns / 1ps
interface ppp_item_if;
  import ppp_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x, point_y, point_z;
  coord_t plane_x, plane_y, plane_z;
  coord_t normal_x, normal_y, normal_z;
  modport source (output valid, point_x, point_y, point_z, plane_x, plane_y, plane_z,
                  normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, point_x, point_y, point_z, plane_x, plane_y, plane_z,
                normal_x, normal_y, normal_z, output ready);
endinterface

interface ppp_result_if;
  import ppp_pkg::*;
  logic    valid;
  logic    ready;
  coord_t  proj_x, proj_y, proj_z;
  status_t status;
  modport source (output valid, proj_x, proj_y, proj_z, status, input ready);
  modport sink (input valid, proj_x, proj_y, proj_z, status, output ready);
endinterface

// File: rtl/ppp_front.sv
// Front end: difference, dot products, classification and overflow check.
`timescale 1ns / 1ps
module ppp_front (
  input  logic             clk,
  input  logic             rst,
  ppp_item_if.sink         items,
  input  ppp_pkg::limits_t limits,
  input  logic             full,
  output logic             push,
  output ppp_pkg::entry_t  entry
);
  import ppp_pkg::*;

  logic adv;
  logic v0, v1, v2, v3, v4;
  geom_t g0, g1, g2, g3, g4;

  logic [MAG_WIDTH-1:0]  dm1 [3];
  logic [MAG_WIDTH-1:0]  nm1 [3];
  logic                  ng1 [3];
  logic [PROD_WIDTH-1:0] sq2 [3];
  logic [PROD_WIDTH-1:0] pr2 [3];
  logic [PROD_WIDTH-1:0] nn2 [3];
  logic                  ng2 [3];
  logic [SUM_WIDTH-1:0]  dist3, pos3, neg3;
  logic [DEN_WIDTH-1:0]  den3, den4;
  logic [SUM_WIDTH-1:0]  mag4;
  logic                  num_neg4, near_hit4;

  coord_t p0 [3];
  coord_t q0 [3];
  coord_t n0 [3];
  logic signed [MAG_WIDTH-1:0] d0 [3];
  logic signed [MAG_WIDTH-1:0] ne0 [3];
  logic [SUM_WIDTH-1:0] pos_c, neg_c;
  logic [SUM_WIDTH-1:0] den_c;

  assign adv         = !v4 || !full;
  assign items.ready = adv;
  assign push        = v4 && !full;

  always_comb begin
    p0[0] = g0.px; p0[1] = g0.py; p0[2] = g0.pz;
    q0[0] = g0.qx; q0[1] = g0.qy; q0[2] = g0.qz;
    n0[0] = g0.nx; n0[1] = g0.ny; n0[2] = g0.nz;
    for (int i = 0; i < 3; i++) begin
      d0[i]  = MAG_WIDTH'($signed(p0[i])) - MAG_WIDTH'($signed(q0[i]));
      ne0[i] = MAG_WIDTH'($signed(n0[i]));
    end
  end

  always_comb begin
    pos_c = '0;
    neg_c = '0;
    den_c = '0;
    for (int i = 0; i < 3; i++) begin
      if (ng2[i]) begin
        neg_c = neg_c + SUM_WIDTH'(pr2[i]);
      end else begin
        pos_c = pos_c + SUM_WIDTH'(pr2[i]);
      end
      den_c = den_c + SUM_WIDTH'(nn2[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
    end else if (adv) begin
      v0 <= items.valid; v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      g0 <= '{px: items.point_x, py: items.point_y, pz: items.point_z,
              qx: items.plane_x, qy: items.plane_y, qz: items.plane_z,
              nx: items.normal_x, ny: items.normal_y, nz: items.normal_z};
      g1 <= g0;
      for (int i = 0; i < 3; i++) begin
        dm1[i] <= d0[i][MAG_WIDTH-1] ? MAG_WIDTH'(-d0[i]) : MAG_WIDTH'(d0[i]);
        nm1[i] <= ne0[i][MAG_WIDTH-1] ? MAG_WIDTH'(-ne0[i]) : MAG_WIDTH'(ne0[i]);
        ng1[i] <= d0[i][MAG_WIDTH-1] ^ ne0[i][MAG_WIDTH-1];
      end
      g2 <= g1;
      for (int i = 0; i < 3; i++) begin
        sq2[i] <= dm1[i] * dm1[i];
        pr2[i] <= dm1[i] * nm1[i];
        nn2[i] <= nm1[i] * nm1[i];
        ng2[i] <= ng1[i];
      end
      g3    <= g2;
      dist3 <= SUM_WIDTH'(sq2[0]) + SUM_WIDTH'(sq2[1]) + SUM_WIDTH'(sq2[2]);
      pos3  <= pos_c;
      neg3  <= neg_c;
      den3  <= den_c[DEN_WIDTH-1:0];
      g4        <= g3;
      num_neg4  <= pos3 < neg3;
      mag4      <= (pos3 < neg3) ? neg3 - pos3 : pos3 - neg3;
      near_hit4 <= dist3 < SUM_WIDTH'(limits.near);
      den4      <= den3;
    end
  end

  always_comb begin
    entry.g       = g4;
    entry.num_neg = num_neg4;
    entry.mag     = mag4;
    entry.den     = den4;
    // quotient of 2^QUO_WIDTH or more: t saturates whatever its sign
    entry.ovf     = OVF_WIDTH'(mag4) >= {den4, {QSHIFT{1'b0}}};
    priority if (near_hit4) begin
      entry.kind = ST_PLANE;
    end else if (mag4 < SUM_WIDTH'(limits.in_plane) || den4 == '0) begin
      entry.kind = ST_IN_PLANE;
    end else begin
      entry.kind = ST_PROJECTED;
    end
  end
endmodule

// File: rtl/ppp_queue.sv
// Short queue of classified items between front and back ends.
`timescale 1ns / 1ps
module ppp_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  ppp_pkg::entry_t wr_entry,
  output logic            full,
  input  logic            pop,
  output ppp_pkg::entry_t head,
  output logic            empty
);
  import ppp_pkg::*;

  entry_t                slots [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0] wr_ptr, rd_ptr;
  logic [QPTR_WIDTH:0]   count;

  assign full  = count == (QPTR_WIDTH+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end
endmodule

// File: rtl/ppp_back.sv
// Back end: pipelined restoring divider, scaling of the normal and saturation.
`timescale 1ns / 1ps
module ppp_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  ppp_pkg::entry_t head,
  output logic            pop,
  ppp_result_if.source    results
);
  import ppp_pkg::*;

  typedef struct packed {
    geom_t                g;
    status_t              kind;
    logic                 num_neg;
    logic                 ovf;
    logic [REM_WIDTH-1:0] rem;
    logic [DEN_WIDTH-1:0] den;
    logic [QUO_WIDTH-1:0] low;
    logic [QUO_WIDTH-1:0] quo;
  } div_t;

  logic adv;
  div_t dv  [QUO_WIDTH+1];
  logic dvv [QUO_WIDTH+1];

  logic    tv, pv;
  geom_t   tg, pg;
  status_t tkind, pkind;
  logic    tsat, psat;
  coord_t  tt;
  logic signed [2*COORD_WIDTH-1:0] prod [3];

  coord_t  t_c;
  logic    tsat_c;
  coord_t  pp [3];
  coord_t  pq [3];
  coord_t  res [3];
  logic    sat_c;
  logic signed [SUMV_WIDTH-1:0] v [3];

  assign adv = !results.valid || results.ready;
  assign pop = adv && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      dvv[0] <= 1'b0;
    end else if (adv) begin
      dvv[0] <= !empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0].g       <= head.g;
      dv[0].kind    <= head.kind;
      dv[0].num_neg <= head.num_neg;
      dv[0].ovf     <= head.ovf;
      dv[0].rem     <= REM_WIDTH'(head.mag >> QSHIFT);
      dv[0].den     <= head.den;
      dv[0].low     <= {head.mag[QSHIFT-1:0], {FRAC_BITS{1'b0}}};
      dv[0].quo     <= '0;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar s = 0; s < QUO_WIDTH; s++) begin : g_div
    div_t                 nxt;
    logic [REM_WIDTH-1:0] trial;
    always_comb begin
      nxt   = dv[s];
      trial = {dv[s].rem[REM_WIDTH-2:0], dv[s].low[QUO_WIDTH-1-s]};
      if (trial >= {1'b0, dv[s].den}) begin
        nxt.rem                 = trial - {1'b0, dv[s].den};
        nxt.quo[QUO_WIDTH-1-s]  = 1'b1;
      end else begin
        nxt.rem = trial;
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        dvv[s+1] <= 1'b0;
      end else if (adv) begin
        dvv[s+1] <= dvv[s];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[s+1] <= nxt;
      end
    end
  end

  always_comb begin
    if (dv[QUO_WIDTH].num_neg) begin
      tsat_c = dv[QUO_WIDTH].ovf || dv[QUO_WIDTH].quo > T_POS_MAX;
      t_c    = tsat_c ? CMAX : coord_t'(dv[QUO_WIDTH].quo);
    end else begin
      tsat_c = dv[QUO_WIDTH].ovf || dv[QUO_WIDTH].quo > T_NEG_MAX;
      t_c    = tsat_c ? CMIN : coord_t'(-dv[QUO_WIDTH].quo);
    end
  end

  always_comb begin
    pp[0] = pg.px; pp[1] = pg.py; pp[2] = pg.pz;
    pq[0] = pg.qx; pq[1] = pg.qy; pq[2] = pg.qz;
    sat_c = psat;
    for (int i = 0; i < 3; i++) begin
      v[i] = SUMV_WIDTH'($signed(pp[i])) + SUMV_WIDTH'(prod[i] >>> FRAC_BITS);
      if (v[i][SUMV_WIDTH-1:COORD_WIDTH-1] != '0 &&
          v[i][SUMV_WIDTH-1:COORD_WIDTH-1] != '1) begin
        res[i] = v[i][SUMV_WIDTH-1] ? CMIN : CMAX;
        sat_c  = 1'b1;
      end else begin
        res[i] = v[i][COORD_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tv            <= 1'b0;
      pv            <= 1'b0;
      results.valid <= 1'b0;
    end else if (adv) begin
      tv            <= dvv[QUO_WIDTH];
      pv            <= tv;
      results.valid <= pv;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tg    <= dv[QUO_WIDTH].g;
      tkind <= dv[QUO_WIDTH].kind;
      tsat  <= tsat_c;
      tt    <= t_c;
      pg      <= tg;
      pkind   <= tkind;
      psat    <= tsat;
      prod[0] <= $signed(tg.nx) * $signed(tt);
      prod[1] <= $signed(tg.ny) * $signed(tt);
      prod[2] <= $signed(tg.nz) * $signed(tt);
      unique case (pkind)
        ST_PLANE: begin
          results.proj_x <= pq[0];
          results.proj_y <= pq[1];
          results.proj_z <= pq[2];
          results.status <= ST_PLANE;
        end
        ST_IN_PLANE: begin
          results.proj_x <= pp[0];
          results.proj_y <= pp[1];
          results.proj_z <= pp[2];
          results.status <= ST_IN_PLANE;
        end
        default: begin
          results.proj_x <= res[0];
          results.proj_y <= res[1];
          results.proj_z <= res[2];
          results.status <= sat_c ? ST_SATURATED : ST_PROJECTED;
        end
      endcase
    end
  end
endmodule

// File: rtl/point_plane_projection.sv
// Top level: orthogonal projection of a point onto a plane, with limit registers.
//
// Items arrive on the items channel (valid/ready, one transfer per accepted
// point): the point, a point on the plane and the normal, signed Q16.16.
// Each item yields exactly one transfer on the results channel: the projected
// point and a status (0 projected, 1 plane point, 2 already in plane,
// 3 saturated). Results keep the order of the items.
// Throughput is one item per cycle while the results receiver does not stall.
// Each item passes five front stages of products and sums ending in the queue
// write, then 37 back stages from the pop, of which 33 are the restoring
// divider, one quotient bit per stage.
// When the results receiver stalls, the back pipeline holds; the front keeps
// accepting until its four-entry queue fills, then deasserts ready.
// Reset (rst, synchronous) empties both pipelines and the queue and sets the
// limits to 1 and 429. The limits are written over the APB port at byte
// addresses 0 and 8 and should only change while no item is in flight.
`timescale 1ns / 1ps
module point_plane_projection (
  input  logic                             clk,
  input  logic                             rst,
  ppp_item_if.sink                         items,
  ppp_result_if.source                     results,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [ppp_pkg::ADDR_WIDTH-1:0]   paddr,
  input  logic [ppp_pkg::DATA_WIDTH-1:0]   pwdata,
  output logic [ppp_pkg::DATA_WIDTH-1:0]   prdata,
  output logic                             pready
);
  import ppp_pkg::*;

  limits_t limits;
  logic    push, full, pop, empty;
  entry_t  wr_entry, head;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_IN_PLANE) ? {1'b0, limits.in_plane}
                                             : {1'b0, limits.near};

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.near     <= NEAR_RESET;
      limits.in_plane <= IN_PLANE_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3])
        REG_NEAR:     limits.near     <= pwdata[LIMIT_WIDTH-1:0];
        REG_IN_PLANE: limits.in_plane <= pwdata[LIMIT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  ppp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (items),
    .limits (limits),
    .full   (full),
    .push   (push),
    .entry  (wr_entry)
  );

  ppp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (wr_entry),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  ppp_back u_back (
    .clk     (clk),
    .rst     (rst),
    .empty   (empty),
    .head    (head),
    .pop     (pop),
    .results (results)
  );
endmodule
